// ===== rtl/core/egcd_pkg.sv =====
// Shared types and constants of the extended binary GCD block.
package egcd_pkg;

  // Fixed field widths of the stream payloads.
  localparam int IN_FIELD_W = 64;
  localparam int IN_DATA_W  = 128;
  localparam int GCD_W      = 63;
  localparam int COEF_W     = 64;
  localparam int OUT_DATA_W = 192;

  // Cofactor constants.
  localparam logic [COEF_W-1:0] COEF_ZERO    = '0;
  localparam logic [COEF_W-1:0] COEF_ONE     = COEF_W'(1);
  localparam logic [COEF_W-1:0] COEF_MINUS_1 = '1;

  typedef logic [COEF_W-1:0] coef_t;

  // Classification of one input transaction, passed from front to back.
  typedef struct packed {
    logic range_err;
    logic a_neg;
    logic b_neg;
  } egcd_flags_t;

  localparam int FLAGS_W = $bits(egcd_flags_t);

endpackage

// ===== rtl/core/egcd_front.sv =====
// Front end: extracts the operands, takes their magnitudes and flags the excluded value.
module egcd_front #(
  parameter int DATA_WIDTH = 64
) (
  input  logic [egcd_pkg::IN_DATA_W-1:0] in_data,
  output logic [2*(DATA_WIDTH-1)-1:0]    abs_pair,
  output egcd_pkg::egcd_flags_t          flags
);
  import egcd_pkg::*;

  localparam int RW = DATA_WIDTH - 1;

  logic [DATA_WIDTH-1:0] a_w;
  logic [DATA_WIDTH-1:0] b_w;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic [DATA_WIDTH-1:0] min_val;

  // Only the low DATA_WIDTH bits of each operand count.
  assign a_w     = in_data[DATA_WIDTH-1:0];
  assign b_w     = in_data[IN_FIELD_W +: DATA_WIDTH];
  assign min_val = {1'b1, {RW{1'b0}}};

  // Magnitudes; with the most negative value excluded they fit in RW bits.
  assign a_mag = a_w[DATA_WIDTH-1] ? (~a_w + {{RW{1'b0}}, 1'b1}) : a_w;
  assign b_mag = b_w[DATA_WIDTH-1] ? (~b_w + {{RW{1'b0}}, 1'b1}) : b_w;

  assign abs_pair = {b_mag[RW-1:0], a_mag[RW-1:0]};

  // Classification carried alongside the magnitudes.
  assign flags.range_err = (a_w == min_val) || (b_w == min_val);
  assign flags.a_neg     = a_w[DATA_WIDTH-1];
  assign flags.b_neg     = b_w[DATA_WIDTH-1];

endmodule

// ===== rtl/core/egcd_fifo.sv =====
// Short register queue between the front end and the iterative back end.
module egcd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer wrap.
  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/egcd_back.sv =====
// Back end: iterative left-to-right shift-and-subtract engine with a result register.
module egcd_back #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            q_empty,
  input  logic [2*(DATA_WIDTH-1)+egcd_pkg::FLAGS_W-1:0]   q_data,
  output logic                                            q_pop,
  input  logic                                            out_ready,
  output logic                                            out_valid,
  output logic [egcd_pkg::GCD_W-1:0]                      out_gcd,
  output egcd_pkg::coef_t                                 out_coef_a,
  output egcd_pkg::coef_t                                 out_coef_b,
  output logic                                            out_err
);
  import egcd_pkg::*;

  localparam int RW = DATA_WIDTH - 1;
  localparam int KW = $clog2(RW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALIGN = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Position of the leading one of a remainder.
  function automatic logic [KW-1:0] msb_index(input logic [RW-1:0] x);
    logic [KW-1:0] idx;
    idx = '0;
    for (int i = 0; i < RW; i++) begin
      if (x[i]) begin
        idx = KW'(i);
      end
    end
    return idx;
  endfunction

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  coef_t                 u_ca_r;
  coef_t                 u_cb_r;
  logic [RW-1:0]         u_rem_r;
  coef_t                 v_ca_r;
  coef_t                 v_cb_r;
  logic [RW-1:0]         v_rem_r;
  logic [KW-1:0]         k_r;
  logic [DATA_WIDTH-1:0] sh_rem_r;
  coef_t                 sh_ca_r;
  coef_t                 sh_cb_r;
  logic [RW-1:0]         abs_a_r;
  logic [RW-1:0]         abs_b_r;
  egcd_flags_t           flags_r;
  logic                  out_valid_r;
  logic [GCD_W-1:0]      out_gcd_r;
  coef_t                 out_ca_r;
  coef_t                 out_cb_r;
  logic                  out_err_r;

  logic [RW-1:0]         q_abs_a;
  logic [RW-1:0]         q_abs_b;
  egcd_flags_t           q_flags;
  logic                  rows_swap;
  logic                  row_zero;
  logic [KW-1:0]         msb_u;
  logic [KW-1:0]         msb_v;
  logic [KW-1:0]         msb_hi;
  logic [KW-1:0]         msb_lo;
  logic [DATA_WIDTH-1:0] u_ext;
  logic                  overshoot;
  logic [DATA_WIDTH-1:0] rem_diff;
  logic                  slot_free;
  coef_t                 s_final;
  coef_t                 t_final;

  // Unpack the queue entry.
  assign q_abs_a = q_data[RW-1:0];
  assign q_abs_b = q_data[2*RW-1:RW];
  assign q_flags = egcd_flags_t'(q_data[2*RW +: FLAGS_W]);

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign slot_free = !out_valid_r || out_ready;

  // Ordering and leading-one search for the alignment step.
  assign rows_swap = (u_rem_r < v_rem_r);
  assign row_zero  = (u_rem_r == '0) || (v_rem_r == '0);
  assign msb_u     = msb_index(u_rem_r);
  assign msb_v     = msb_index(v_rem_r);
  assign msb_hi    = rows_swap ? msb_v : msb_u;
  assign msb_lo    = rows_swap ? msb_u : msb_v;

  // Subtraction step: magnitude of the difference and its sign.
  assign u_ext     = {1'b0, u_rem_r};
  assign overshoot = (sh_rem_r > u_ext);
  assign rem_diff  = overshoot ? (sh_rem_r - u_ext) : (u_ext - sh_rem_r);

  // Final cofactors, with the two trivial cases handled directly.
  always_comb begin
    if (u_rem_r == abs_a_r) begin
      s_final = flags_r.a_neg ? COEF_MINUS_1 : COEF_ONE;
      t_final = COEF_ZERO;
    end else if (u_rem_r == abs_b_r) begin
      s_final = COEF_ZERO;
      t_final = flags_r.b_neg ? COEF_MINUS_1 : COEF_ONE;
    end else begin
      s_final = flags_r.a_neg ? (COEF_ZERO - u_ca_r) : u_ca_r;
      t_final = flags_r.b_neg ? (COEF_ZERO - u_cb_r) : u_cb_r;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_flags.range_err ? ST_DONE : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        state_nxt = row_zero ? ST_DONE : ST_SHIFT;
      end
      ST_SHIFT: begin
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        state_nxt = ST_ALIGN;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working rows and operand copies.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          abs_a_r <= q_abs_a;
          abs_b_r <= q_abs_b;
          flags_r <= q_flags;
          if (!q_flags.range_err) begin
            u_ca_r  <= COEF_ONE;
            u_cb_r  <= COEF_ZERO;
            u_rem_r <= q_abs_a;
            v_ca_r  <= COEF_ZERO;
            v_cb_r  <= COEF_ONE;
            v_rem_r <= q_abs_b;
          end
        end
      end
      ST_ALIGN: begin
        // Keep the larger remainder in row u.
        if (rows_swap) begin
          u_ca_r  <= v_ca_r;
          u_cb_r  <= v_cb_r;
          u_rem_r <= v_rem_r;
          v_ca_r  <= u_ca_r;
          v_cb_r  <= u_cb_r;
          v_rem_r <= u_rem_r;
        end
        k_r <= msb_hi - msb_lo;
      end
      ST_SHIFT: begin
        sh_rem_r <= {1'b0, v_rem_r} << k_r;
        sh_ca_r  <= v_ca_r << k_r;
        sh_cb_r  <= v_cb_r << k_r;
      end
      ST_SUB: begin
        // A negative difference flips the sign of the whole row.
        u_rem_r <= rem_diff[RW-1:0];
        u_ca_r  <= overshoot ? (sh_ca_r - u_ca_r) : (u_ca_r - sh_ca_r);
        u_cb_r  <= overshoot ? (sh_cb_r - u_cb_r) : (u_cb_r - sh_cb_r);
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && slot_free) begin
      if (flags_r.range_err) begin
        out_gcd_r <= '0;
        out_ca_r  <= COEF_ZERO;
        out_cb_r  <= COEF_ZERO;
        out_err_r <= 1'b1;
      end else begin
        out_gcd_r <= GCD_W'(u_rem_r);
        out_ca_r  <= s_final;
        out_cb_r  <= t_final;
        out_err_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_gcd    = out_gcd_r;
  assign out_coef_a = out_ca_r;
  assign out_coef_b = out_cb_r;
  assign out_err    = out_err_r;

  // Rows are ordered and the divisor row is live when a shift is taken.
  a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> (u_rem_r >= v_rem_r) && (v_rem_r != '0))
    else $error("working rows out of order at shift step");

  // The aligned divisor stays below twice the current remainder.
  a_shift_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUB |-> sh_rem_r < {u_rem_r, 1'b0})
    else $error("aligned divisor overshoots remainder");

  // An item taken from the queue starts the loop or goes straight to the result.
  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_ALIGN) || (state_r == ST_DONE))
    else $error("queue pop did not start an item");

  // A finished item waits while the result register is still occupied.
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_ready |=> state_r == ST_DONE)
    else $error("result overwritten while still pending");

  // An excluded operand yields an all-zero payload.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> (out_gcd_r == '0) && (out_ca_r == COEF_ZERO)
      && (out_cb_r == COEF_ZERO))
    else $error("range error result carries data");

endmodule

// ===== rtl/core/extended_binary_l2r_gcd.sv =====
// Top level of the left-to-right extended binary GCD block.
// Each input transaction carries two signed operands a and b (low DATA_WIDTH bits count);
// each output transaction returns g = gcd(|a|,|b|) with cofactors s, t such that
// g = s*a + t*b. The front end classifies and stores up to two items in a queue, so
// input is taken while the engine works and while a finished result waits. The engine
// runs one item at a time: it loads the item, runs shift-and-subtract iterations (align
// and swap, shift, subtract), takes one more alignment step that finds the smaller
// remainder at zero, then writes the result register. An excluded operand goes from the
// load straight to the result write. A result still waiting in the output register holds
// the engine in its result-write state. The single shared shift-subtract loop sets the
// rate. An operand equal to the most negative value gives a result with the range error
// flag set and zeros.
module extended_binary_l2r_gcd #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [egcd_pkg::IN_DATA_W-1:0]    in_tdata,   // a_value[63:0], b_value[127:64]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [egcd_pkg::OUT_DATA_W-1:0]   out_tdata,  // gcd_result[62:0], coef_a[126:63],
                                                        // coef_b[190:127], zero pad [191]
  output logic                              out_tuser   // range_error
);
  import egcd_pkg::*;

  localparam int RW      = DATA_WIDTH - 1;
  localparam int ENTRY_W = 2 * RW + FLAGS_W;

  logic [2*RW-1:0]    abs_pair;
  egcd_flags_t        flags;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic [GCD_W-1:0]   res_gcd;
  coef_t              res_ca;
  coef_t              res_cb;

  // Classification of the incoming transaction.
  egcd_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .in_data  (in_tdata),
    .abs_pair (abs_pair),
    .flags    (flags)
  );

  assign q_wdata   = {flags, abs_pair};
  assign in_tready = !q_full;

  // Queue between front and back.
  egcd_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Iterative engine and result register.
  egcd_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_gcd    (res_gcd),
    .out_coef_a (res_ca),
    .out_coef_b (res_cb),
    .out_err    (out_tuser)
  );

  // Result packing, first field in the lowest bits.
  assign out_tdata = {1'b0, res_cb, res_ca, res_gcd};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the extended binary GCD stream block.
`timescale 1ns / 100ps

module tb;
  import egcd_pkg::*;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 500;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

  // One result transaction as the block should return it.
  typedef struct packed {
    logic                 range_err;
    coef_t                coef_b;
    coef_t                coef_a;
    logic [GCD_W-1:0]     gcd;
  } bezout_t;

  // Predicts each result and checks the returned transactions in order.
  class bezout_scoreboard;
    bezout_t expected_bezout[$];
    int      error_count;
    int      checked_count;
    int      range_count;
    int      trivial_count;
    // Working rows, kept between transactions as the block keeps them.
    logic [63:0] u_a, u_b, u_r, v_a, v_b, v_r;

    function new();
      u_a = 64'd1; u_b = 64'd0; u_r = 64'd0;
      v_a = 64'd0; v_b = 64'd1; v_r = 64'd0;
    endfunction

    function int pending();
      return expected_bezout.size();
    endfunction

    function int msb_index(logic [63:0] x);
      for (int i = 63; i > 0; i--)
        if (x[i]) return i;
      return 0;
    endfunction

    // Keeps the row with the larger remainder in u.
    function void order_rows();
      logic [63:0] h;
      if (u_r < v_r) begin
        h = u_a; u_a = v_a; v_a = h;
        h = u_b; u_b = v_b; v_b = h;
        h = u_r; u_r = v_r; v_r = h;
      end
    endfunction

    function bezout_t bezout_of(logic [63:0] a, logic [63:0] b);
      bezout_t     r;
      logic        a_neg, b_neg;
      logic [63:0] abs_a, abs_b, shifted, s, t;
      int          k;
      r = '0;
      if (a == MOST_NEG || b == MOST_NEG) begin
        r.range_err = 1'b1;
        return r;
      end
      a_neg = a[63];
      b_neg = b[63];
      abs_a = a_neg ? 64'd0 - a : a;
      abs_b = b_neg ? 64'd0 - b : b;
      u_a = 64'd1; u_b = 64'd0; u_r = abs_a;
      v_a = 64'd0; v_b = 64'd1; v_r = abs_b;
      order_rows();
      // Subtract the aligned smaller row until the smaller remainder is zero.
      while (v_r != 64'd0) begin
        k = msb_index(u_r) - msb_index(v_r);
        shifted = v_r << k;
        u_a = u_a - (v_a << k);
        u_b = u_b - (v_b << k);
        if (shifted > u_r) begin
          u_r = shifted - u_r;
          u_a = 64'd0 - u_a;
          u_b = 64'd0 - u_b;
        end else begin
          u_r = u_r - shifted;
        end
        order_rows();
      end
      // Where the gcd is one operand, the cofactors are fixed by its sign.
      if (u_r == abs_a) begin
        s = a_neg ? COEF_MINUS_1 : COEF_ONE;
        t = COEF_ZERO;
      end else if (u_r == abs_b) begin
        s = COEF_ZERO;
        t = b_neg ? COEF_MINUS_1 : COEF_ONE;
      end else begin
        s = a_neg ? 64'd0 - u_a : u_a;
        t = b_neg ? 64'd0 - u_b : u_b;
      end
      r.gcd    = u_r[GCD_W-1:0];
      r.coef_a = s;
      r.coef_b = t;
      return r;
    endfunction

    function void note_operands(logic [63:0] a, logic [63:0] b);
      bezout_t r;
      r = bezout_of(a, b);
      if (r.range_err) range_count++;
      else if (r.coef_a == COEF_ZERO || r.coef_b == COEF_ZERO) trivial_count++;
      expected_bezout.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
      bezout_t exp_r;
      bezout_t got;
      got.gcd       = data[62:0];
      got.coef_a    = data[126:63];
      got.coef_b    = data[190:127];
      got.range_err = user;
      checked_count++;
      if (expected_bezout.size() == 0) begin
        $error("Unexpected result transaction: gcd_result=%0d", got.gcd);
        error_count++;
        return;
      end
      exp_r = expected_bezout.pop_front();
      if (got.gcd !== exp_r.gcd) begin
        $error("gcd_result: expected %0d, got %0d", exp_r.gcd, got.gcd);
        error_count++;
      end
      if (got.coef_a !== exp_r.coef_a) begin
        $error("coef_a: expected %0d, got %0d", $signed(exp_r.coef_a), $signed(got.coef_a));
        error_count++;
      end
      if (got.coef_b !== exp_r.coef_b) begin
        $error("coef_b: expected %0d, got %0d", $signed(exp_r.coef_b), $signed(got.coef_b));
        error_count++;
      end
      if (got.range_err !== exp_r.range_err) begin
        $error("range_error: expected %0b, got %0b", exp_r.range_err, got.range_err);
        error_count++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  bezout_scoreboard sb = new();
  bit  steady_run;
  int  idle_cycles;
  int  accepted_count;

  extended_binary_l2r_gcd dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, occasionally a long one, none in a steady phase.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (w <= 0) return '0;
    if (w >= 64) return r;
    return r >> (64 - w);
  endfunction

  function automatic logic [63:0] rand_sign(logic [63:0] v);
    return ($urandom_range(0, 1) == 1) ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] edge_operand();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return -64'sd1;
      3:       return MAX_POS;
      4:       return 64'd0 - MAX_POS;
      5:       return MOST_NEG;
      default: return rand_bits(64);
    endcase
  endfunction

  // Random operand pairs, many with a common factor or dividing one another.
  task automatic make_operands(output logic [63:0] a, output logic [63:0] b);
    int          wg;
    logic [63:0] g;
    logic [63:0] h;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        a = rand_bits(64);
        b = rand_bits(64);
      end
      3, 4, 5: begin
        wg = $urandom_range(1, 30);
        g  = rand_bits(wg);
        a  = rand_sign(g * rand_bits($urandom_range(1, 62 - wg)));
        b  = rand_sign(g * rand_bits($urandom_range(1, 62 - wg)));
      end
      6, 7: begin
        a = rand_sign(rand_bits($urandom_range(1, 16)));
        b = rand_sign(rand_bits($urandom_range(1, 16)));
      end
      8: begin
        g = rand_bits($urandom_range(1, 31));
        a = rand_sign(g);
        b = rand_sign(g * rand_bits($urandom_range(1, 31)));
        if ($urandom_range(0, 1) == 1) begin
          h = a; a = b; b = h;
        end
      end
      default: begin
        a = edge_operand();
        b = edge_operand();
      end
    endcase
  endtask

  // Presents one operand pair and waits until it is accepted.
  task automatic send_operands(input logic [63:0] a, input logic [63:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending until every outstanding result has been returned.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  // Result-side back-pressure.
  initial begin
    int n;
    int m;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_tready <= 1'b1;
      n = steady_run ? 1 : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      m = gap_len();
      if (m > 0) begin
        out_tready <= 1'b0;
        repeat (m) @(posedge clk);
      end
    end
  end

  // Transaction monitor on both channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_operands(in_tdata[63:0], in_tdata[127:64]);
        accepted_count++;
      end
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reset, directed operands, random operands and final report.
  initial begin
    logic [63:0] a;
    logic [63:0] b;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    steady_run = 1'b0;
    idle_cycles    = 0;
    accepted_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero operands, most negative values, extremes and one operand dividing the other.
    send_operands(64'd0, 64'd0);
    send_operands(64'd5, 64'd0);
    send_operands(64'd0, 64'd7);
    send_operands(-64'sd5, 64'd0);
    send_operands(64'd0, -64'sd7);
    send_operands(MOST_NEG, 64'd3);
    send_operands(64'd3, MOST_NEG);
    send_operands(MOST_NEG, MOST_NEG);
    send_operands(MAX_POS, MAX_POS);
    send_operands(MAX_POS, 64'd0 - MAX_POS);
    send_operands(64'd0 - MAX_POS, 64'd1);
    send_operands(64'd1, -64'sd1);
    send_operands(64'd12, 64'd36);
    send_operands(64'd36, -64'sd12);
    send_operands(-64'sd12, -64'sd36);
    send_operands(64'd240, 64'd46);
    send_operands(-64'sd240, 64'd46);
    send_operands(MAX_POS, MAX_POS - 64'd1);
    send_operands(64'h4000_0000_0000_0000, 64'h0000_0300_0000_0000);
    send_operands(64'd0 - MAX_POS, 64'd2);
    send_operands(64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAB);
    hold_until_drained();

    // Random operands in phases, some without any idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 250 == 0) steady_run <= ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      make_operands(a, b);
      send_operands(a, b);
    end
    in_tvalid <= 1'b0;

    do @(negedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d expected results never returned", sb.pending());
      sb.error_count++;
    end
    $display("Checked %0d results of %0d pairs: %0d range errors, %0d zero cofactors.",
             sb.checked_count, accepted_count, sb.range_count, sb.trivial_count);
    $display("Mismatches found: %0d.", sb.error_count);
    if (sb.error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
